// ===== rtl/pli_pkg.sv =====
`timescale 1ns / 1ps

package pli_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_NODES_DEF = 64;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SH_RD,
    S_SH_CHK,
    S_INS,
    S_QF_RD,
    S_QF_CHK,
    S_QL_RD,
    S_QL_CHK,
    S_BS_RD,
    S_BS_CHK,
    S_P1_RD,
    S_P1_CHK,
    S_P2_RD,
    S_P2_CHK
  } state_t;

  // S_MD and S_RESP are kept in a separate small flag set to fit four bits.
  typedef struct packed {
    logic                start;
    logic [DATA_W:0]     mag;
    logic [DATA_W-1:0]   mult;
    logic [DATA_W-1:0]   divisor;
  } md_req_t;

  typedef struct packed {
    logic                done;
    logic [DATA_W:0]     quot;
  } md_rsp_t;

endpackage

// ===== rtl/pli_ram.sv =====
`timescale 1ns / 1ps

module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pli_muldiv.sv =====
`timescale 1ns / 1ps

module pli_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  pli_pkg::md_req_t req,
  output pli_pkg::md_rsp_t rsp
);

  import pli_pkg::*;

  // One shift-add multiply (DATA_W steps) followed by a restoring divide
  // of the 2*DATA_W bit product (2*DATA_W steps), one bit per cycle.
  localparam int CW = $clog2(2 * DATA_W);

  logic              running;
  logic              div_phase;
  logic [CW-1:0]     step;
  logic [DATA_W:0]   mag;
  logic [DATA_W-1:0] divisor;
  logic [DATA_W:0]   hi;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] rem;
  logic              done;

  logic [DATA_W+1:0] sum;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              qbit;

  always_comb begin
    sum   = {1'b0, hi} + (lo[0] ? {1'b0, mag} : '0);
    trial = {rem, hi[DATA_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running   <= 1'b1;
        div_phase <= 1'b0;
        step      <= '0;
        mag       <= req.mag;
        divisor   <= req.divisor;
        hi        <= '0;
        lo        <= req.mult;
        rem       <= '0;
      end else if (running) begin
        if (!div_phase) begin
          hi   <= sum[DATA_W+1:1];
          lo   <= {sum[0], lo[DATA_W-1:1]};
          step <= step + 1'b1;
          if (step == CW'(DATA_W - 1)) begin
            div_phase <= 1'b1;
            step      <= '0;
          end
        end else begin
          // The product sits in {hi[DATA_W-1:0], lo}; quotient bits shift in at the bottom.
          rem  <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
          hi   <= {1'b0, hi[DATA_W-2:0], lo[DATA_W-1]};
          lo   <= {lo[DATA_W-2:0], qbit};
          step <= step + 1'b1;
          if (step == CW'(2 * DATA_W - 1)) begin
            running <= 1'b0;
            done    <= 1'b1;
          end
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = {hi[0], lo};

endmodule

// ===== rtl/piecewise_linear_interpolator_top.sv =====
`timescale 1ns / 1ps
// Clear and unused commands give their result in the cycle after the request is taken.
// An add reads each stored node to look for the same x, then shifts up every node whose
// x is larger and writes the new one into the gap. A query checks x against the first
// and last node; unless it is out of range or equal to the last x, a binary search
// finds the segment, its end nodes are read and the bit-serial multiply and divide run.
// One request at a time; the result strobe lasts one cycle and cannot be stalled.
// Synchronous reset empties the table and clears the bad flag, not the table memory.

module piecewise_linear_interpolator_top #(
  parameter int MAX_NODES = pli_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      cmd,
  input  logic signed [pli_pkg::DATA_W-1:0] x_value,
  input  logic signed [pli_pkg::DATA_W-1:0] y_value,
  output logic                            done,
  output logic signed [pli_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                      status
);

  import pli_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  state_t state, state_next;
  logic   in_md, in_md_next;
  logic   in_resp, in_resp_next;

  logic [CNT_W-1:0]         count;
  logic                     bad;
  logic [CNT_W-1:0]         k;
  logic [CNT_W-1:0]         lo;
  logic [CNT_W-1:0]         hi;
  logic signed [DATA_W-1:0] xin;
  logic signed [DATA_W-1:0] yin;
  logic signed [DATA_W-1:0] x1;
  logic signed [DATA_W-1:0] y1;
  logic                     neg;
  logic signed [DATA_W-1:0] res;
  logic [1:0]               st;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [DATA_W-1:0]        wdata_x;
  logic [DATA_W-1:0]        wdata_y;
  logic [IDX_W-1:0]         raddr;
  logic [DATA_W-1:0]        rd_x_raw;
  logic [DATA_W-1:0]        rd_y_raw;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;

  logic [CNT_W:0]           mid_sum;
  logic [CNT_W-1:0]         mid;
  logic [CNT_W-1:0]         lo_new;
  logic [CNT_W-1:0]         hi_new;
  logic signed [DATA_W:0]   dy;
  logic                     full;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic signed [DATA_W+1:0] qs;
  logic signed [DATA_W+1:0] y_sum;

  assign rd_x = $signed(rd_x_raw);
  assign rd_y = $signed(rd_y_raw);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign full    = (count == CNT_W'(MAX_NODES));
  assign dy      = {rd_y[DATA_W-1], rd_y} - {y1[DATA_W-1], y1};

  always_comb begin
    if (rd_x > xin) begin
      hi_new = mid;
      lo_new = lo;
    end else begin
      hi_new = hi;
      lo_new = mid + 1'b1;
    end
  end

  assign qs    = neg ? -$signed({1'b0, md_rsp.quot}) : $signed({1'b0, md_rsp.quot});
  assign y_sum = {{2{y1[DATA_W-1]}}, y1} + qs;

  pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_ram_x (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_x),
    .raddr (raddr),
    .rdata (rd_x_raw)
  );

  pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_ram_y (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_y),
    .raddr (raddr),
    .rdata (rd_y_raw)
  );

  pli_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Next state.
  always_comb begin
    state_next   = state;
    in_md_next   = in_md;
    in_resp_next = 1'b0;
    if (in_resp) begin
      state_next = S_IDLE;
    end else if (in_md) begin
      if (md_rsp.done) begin
        in_md_next   = 1'b0;
        in_resp_next = 1'b1;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd == CMD_ADD) begin
              if (full) begin
                in_resp_next = 1'b1;
              end else if (count == '0) begin
                state_next = S_INS;
              end else begin
                state_next = S_SCAN_RD;
              end
            end else if (cmd == CMD_QUERY) begin
              if (bad || count == '0) begin
                in_resp_next = 1'b1;
              end else begin
                state_next = S_QF_RD;
              end
            end else begin
              in_resp_next = 1'b1;
            end
          end
        end
        S_SCAN_RD:  state_next = S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (rd_x == xin) begin
            in_resp_next = 1'b1;
          end else if (k + 1'b1 == count) begin
            state_next = S_SH_RD;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
        S_SH_RD:  state_next = S_SH_CHK;
        S_SH_CHK: begin
          if (rd_x > xin && k != CNT_W'(1)) begin
            state_next = S_SH_RD;
          end else begin
            state_next = S_INS;
          end
        end
        S_INS:    in_resp_next = 1'b1;
        S_QF_RD:  state_next = S_QF_CHK;
        S_QF_CHK: begin
          if (xin < rd_x) begin
            in_resp_next = 1'b1;
          end else begin
            state_next = S_QL_RD;
          end
        end
        S_QL_RD:  state_next = S_QL_CHK;
        S_QL_CHK: begin
          if (xin >= rd_x) begin
            in_resp_next = 1'b1;
          end else begin
            state_next = S_BS_RD;
          end
        end
        S_BS_RD:  state_next = S_BS_CHK;
        S_BS_CHK: begin
          if (lo_new < hi_new) begin
            state_next = S_BS_RD;
          end else begin
            state_next = S_P1_RD;
          end
        end
        S_P1_RD:  state_next = S_P1_CHK;
        S_P1_CHK: state_next = S_P2_RD;
        S_P2_RD:  state_next = S_P2_CHK;
        S_P2_CHK: in_md_next = 1'b1;
        default:  state_next = S_IDLE;
      endcase
    end
  end

  // Memory and unit controls.
  always_comb begin
    we             = 1'b0;
    waddr          = k[IDX_W-1:0];
    wdata_x        = rd_x_raw;
    wdata_y        = rd_y_raw;
    raddr          = '0;
    md_req.start   = 1'b0;
    md_req.mag     = dy[DATA_W] ? (DATA_W+1)'(0) - dy : dy;
    md_req.mult    = xin - x1;
    md_req.divisor = rd_x - x1;
    if (!in_md && !in_resp) begin
      unique case (state)
        S_SCAN_RD:  raddr = k[IDX_W-1:0];
        S_SH_RD:    raddr = IDX_W'(k - 1'b1);
        S_SH_CHK:   we = (rd_x > xin);
        S_INS: begin
          we      = 1'b1;
          wdata_x = xin;
          wdata_y = yin;
        end
        S_QL_RD:    raddr = IDX_W'(count - 1'b1);
        S_BS_RD:    raddr = mid[IDX_W-1:0];
        S_P1_RD:    raddr = IDX_W'(lo - 1'b1);
        S_P2_RD:    raddr = lo[IDX_W-1:0];
        S_P2_CHK:   md_req.start = 1'b1;
        default:    raddr = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_md   <= 1'b0;
      in_resp <= 1'b0;
      count   <= '0;
      bad     <= 1'b0;
    end else begin
      state   <= state_next;
      in_md   <= in_md_next;
      in_resp <= in_resp_next;
      if (in_md) begin
        if (md_rsp.done) begin
          res <= y_sum[DATA_W-1:0];
          st  <= ST_OK;
        end
      end else if (!in_resp) begin
        unique case (state)
          S_IDLE: begin
            xin <= x_value;
            yin <= y_value;
            k   <= '0;
            res <= '0;
            st  <= ST_OK;
            if (start) begin
              if (cmd == CMD_CLEAR) begin
                count <= '0;
                bad   <= 1'b0;
              end else if (cmd == CMD_ADD) begin
                if (full) begin
                  st <= ST_FULL;
                end
              end else if (cmd == CMD_QUERY) begin
                if (bad) begin
                  st <= ST_BAD;
                end else if (count == '0) begin
                  st <= ST_RANGE;
                end
              end
            end
          end
          S_SCAN_CHK: begin
            if (rd_x == xin) begin
              bad <= 1'b1;
              st  <= ST_BAD;
            end else if (k + 1'b1 == count) begin
              k <= count;
            end else begin
              k <= k + 1'b1;
            end
          end
          S_SH_CHK: begin
            if (rd_x > xin) begin
              k <= k - 1'b1;
            end
          end
          S_INS: begin
            count <= count + 1'b1;
            st    <= bad ? ST_BAD : ST_OK;
          end
          S_QF_CHK: begin
            if (xin < rd_x) begin
              st <= ST_RANGE;
            end
          end
          S_QL_CHK: begin
            lo <= '0;
            hi <= count - 1'b1;
            if (xin > rd_x) begin
              st <= ST_RANGE;
            end else if (xin == rd_x) begin
              res <= rd_y;
            end
          end
          S_BS_CHK: begin
            hi <= hi_new;
            lo <= (lo_new == '0) ? CNT_W'(1) : lo_new;
          end
          S_P1_CHK: begin
            x1 <= rd_x;
            y1 <= rd_y;
          end
          S_P2_CHK: neg <= dy[DATA_W];
          default: begin
          end
        endcase
      end
    end
  end

  assign busy         = (state != S_IDLE) || in_md || in_resp;
  assign done         = in_resp;
  assign result_value = res;
  assign status       = st;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pli_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_CLEAR;
  logic signed [31:0] x_value = '0;
  logic signed [31:0] y_value = '0;
  logic busy;
  logic done;
  logic signed [31:0] result_value;
  logic [1:0] status;

  logic signed [31:0] node_x[NODES];
  logic signed [31:0] node_y[NODES];
  int node_total = 0;
  bit nodes_bad = 0;

  answer_t pending_answers[$];
  int errors = 0;
  int requests_sent = 0;
  int burst_left = 0;

  piecewise_linear_interpolator_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .x_value(x_value), .y_value(y_value), .done(done),
    .result_value(result_value), .status(status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  task automatic interpolate_request(input logic [1:0] c, input logic signed [31:0] x,
                                     input logic signed [31:0] y, output answer_t a);
    int pos, lo, hi, mid;
    longint x1, x2, y1, y2, dy;
    logic [63:0] mag, dx, dxq, prod, q;
    a.value = '0;
    a.status = ST_OK;
    case (c)
      CMD_CLEAR: begin
        node_total = 0;
        nodes_bad = 0;
      end
      CMD_ADD: begin
        if (node_total >= NODES) begin
          a.status = ST_FULL;
          return;
        end
        for (int k = 0; k < node_total; k++) begin
          if (node_x[k] == x) begin
            nodes_bad = 1;
            a.status = ST_BAD;
            return;
          end
        end
        pos = node_total;
        while (pos > 0 && node_x[pos-1] > x) begin
          node_x[pos] = node_x[pos-1];
          node_y[pos] = node_y[pos-1];
          pos--;
        end
        node_x[pos] = x;
        node_y[pos] = y;
        node_total++;
        if (nodes_bad) a.status = ST_BAD;
      end
      CMD_QUERY: begin
        if (nodes_bad) a.status = ST_BAD;
        else if (node_total == 0 || x < node_x[0] || x > node_x[node_total-1])
          a.status = ST_RANGE;
        else if (x == node_x[node_total-1]) a.value = node_y[node_total-1];
        else begin
          lo = 0;
          hi = node_total - 1;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (node_x[mid] > x) hi = mid;
            else lo = mid + 1;
          end
          if (lo == 0) lo = 1;
          x1 = node_x[lo-1];
          y1 = node_y[lo-1];
          x2 = node_x[lo];
          y2 = node_y[lo];
          dy = y2 - y1;
          dx = x2 - x1;
          dxq = longint'(x) - x1;
          mag = (dy < 0) ? -dy : dy;
          prod = mag * dxq;
          q = prod / dx;
          a.value = (dy < 0) ? 32'(y1 - longint'(q)) : 32'(y1 + longint'(q));
        end
      end
      default: ;
    endcase
  endtask

  // Sends one request; start stays high afterwards so a burst runs back to back.
  task automatic send_request(input logic [1:0] c, input logic signed [31:0] x,
                              input logic signed [31:0] y);
    int gap;
    answer_t a;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    cmd <= c;
    x_value <= x;
    y_value <= y;
    do @(posedge clk); while (busy);
    interpolate_request(c, x, y, a);
    pending_answers.insert(pending_answers.size(), a);
    requests_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    answer_t a;
    if (!rst && done) begin
      if (pending_answers.size() == 0) report("result with no request outstanding");
      else begin
        a = pending_answers.pop_front();
        if (result_value !== a.value)
          report($sformatf("result_value %h, expected %h", result_value, a.value));
        if (status !== a.status)
          report($sformatf("status %0d, expected %0d", status, a.status));
      end
    end
  end

  task automatic test_basic;
    send_request(CMD_CLEAR, 0, 0);
    send_request(CMD_QUERY, 0, 0);
    send_request(CMD_UNUSED, 32'h7fffffff, 32'h80000000);
    send_request(CMD_ADD, 32'h7fffffff, 32'h7fffffff);
    send_request(CMD_QUERY, 32'h7fffffff, 0);
    send_request(CMD_ADD, 32'h80000000, 32'h80000000);
    send_request(CMD_QUERY, 32'h80000000, 0);
    send_request(CMD_QUERY, 0, 0);
    send_request(CMD_QUERY, 32'h7ffffffe, 0);
    send_request(CMD_ADD, 0, 32'h7fffffff);
    send_request(CMD_QUERY, 32'h3fffffff, 0);
    send_request(CMD_QUERY, 32'hc0000001, 0);
    send_request(CMD_CLEAR, 0, 0);
    send_request(CMD_ADD, 32'h00010000, 32'h00020000);
    send_request(CMD_ADD, 32'h00030000, 32'hfffe0000);
    send_request(CMD_QUERY, 32'h0000ffff, 0);
    send_request(CMD_QUERY, 32'h00030001, 0);
    send_request(CMD_QUERY, 32'h00018000, 0);
    send_request(CMD_ADD, 32'h00010000, 32'h5);
    send_request(CMD_ADD, 32'h00050000, 32'h5);
    send_request(CMD_QUERY, 32'h00018000, 0);
    send_request(CMD_QUERY, 32'h7fffffff, 0);
    send_request(CMD_CLEAR, 0, 0);
    send_request(CMD_QUERY, 32'h00018000, 0);
    drain();
  endtask

  task automatic test_full_table;
    send_request(CMD_CLEAR, 0, 0);
    for (int k = 0; k < NODES; k++) send_request(CMD_ADD, $urandom, $urandom);
    send_request(CMD_ADD, $urandom, $urandom);
    send_request(CMD_QUERY, node_x[NODES/2], 0);
    drain();
  endtask

  task automatic test_random;
    int n, nq, k;
    logic signed [31:0] x;
    longint span;
    while (requests_sent < 1350) begin
      send_request(CMD_CLEAR, $urandom, $urandom);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        // A narrow spread of x now and then produces duplicates.
        if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 15) << 16;
        else x = $urandom;
        send_request(CMD_ADD, x, $urandom);
      end
      nq = $urandom_range(1, 12);
      for (int i = 0; i < nq; i++) begin
        k = $urandom_range(0, 9);
        if (k < 7 && node_total >= 2) begin
          k = $urandom_range(0, node_total - 2);
          span = longint'(node_x[k+1]) - longint'(node_x[k]);
          x = 32'(longint'(node_x[k]) + ({$urandom, $urandom} % span));
          send_request(CMD_QUERY, x, $urandom);
        end else if (k == 7 && node_total > 0)
          send_request(CMD_QUERY, node_x[$urandom_range(0, node_total - 1)], $urandom);
        else if (k == 8) send_request(CMD_QUERY, $urandom, $urandom);
        else if ($urandom_range(0, 1) == 0) send_request(CMD_UNUSED, $urandom, $urandom);
        else if (node_total > 0)
          send_request(CMD_ADD, node_x[$urandom_range(0, node_total - 1)], $urandom);
        else send_request(CMD_QUERY, $urandom, $urandom);
      end
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic();
    test_full_table();
    test_random();
    repeat (200) @(posedge clk);
    if (pending_answers.size() > 0) report("results still outstanding at the end");
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== piecewise_linear_interpolator_top.f =====
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/pli_muldiv.sv
rtl/piecewise_linear_interpolator_top.sv
test/tb.sv
